@@ hdl/top_k_score_table_defines.svh @@
// Assertion macros for the score table RTL.
`ifndef TOP_K_SCORE_TABLE_DEFINES_SVH
`define TOP_K_SCORE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// A property checked at every clock edge outside reset.
`define TKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another in the next cycle.
`define TKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TKST_ASSERT(lbl, prop, msg)
`define TKST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/tkst_pkg.sv @@
// Types, constants and the name clean-up function of the score table.
`default_nettype none
package tkst_pkg;

  localparam int SCORE_W           = 32;
  localparam int NAME_BYTES        = 32;
  localparam int NAME_W            = 256;
  localparam int DEF_TABLE_ENTRIES = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [NAME_W-1:0]         name;
  } entry_t;

  // Copies bytes up to the first zero byte, keeping at most NAME_BYTES-1 of them.
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (i >= NAME_BYTES - 1 || raw[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[i*8 +: 8] = raw[i*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tkst_store.sv @@
// Entry memory of the score table: one write port, one registered read port.
`default_nettype none
module tkst_store
  import tkst_pkg::*;
#(
  parameter  int DEPTH  = DEF_TABLE_ENTRIES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/top_k_score_table.sv @@
// Top level of the sorted top-score table with its insert and read sequencer.
// The block keeps the best TABLE_ENTRIES scores in descending order, each with a
// name of up to 31 bytes. A transaction is accepted at a clock edge where start
// is high and busy is low; in_operation selects an insert of in_score with its
// name, or a read of the entry at in_entry_index.
// Every transaction yields exactly one result, shown on the out_ ports for one
// cycle while out_valid is high; the receiver cannot stall, so nothing is held.
// A read registers the memory word into the result in S_RDOUT. An insert walks
// upward from the bottom of the table, moving one entry down per cycle through
// the single read port of the entry memory, and then writes the new score into
// its place. On a full table a check against the bottom entry comes first, but
// that entry is then dropped rather than moved; a refused insert returns its
// result straight from the check. busy falls in the cycle that shows the
// result, so the next transaction may be accepted there. Reset empties the
// table by clearing the entry count; memory rows beyond the count are never
// returned.
`default_nettype none
`include "top_k_score_table_defines.svh"
module top_k_score_table
  import tkst_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [3:0]                in_entry_index,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [63:0]               in_name_word0,
  input  logic [63:0]               in_name_word1,
  input  logic [63:0]               in_name_word2,
  input  logic [63:0]               in_name_word3,
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic [3:0]                out_placed_at,
  output logic [4:0]                out_entry_count,
  output logic                      out_entry_valid,
  output logic signed [SCORE_W-1:0] out_entry_score,
  output logic [63:0]               out_entry_name0,
  output logic [63:0]               out_entry_name1,
  output logic [63:0]               out_entry_name2,
  output logic [63:0]               out_entry_name3
);

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W  = CNT_W + 4;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_PLACE,
    S_RDOUT
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          count_r;
  logic [ADDR_W-1:0]         slot_r;
  logic [3:0]                idx_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [NAME_W-1:0]         name_r;

  logic                      out_valid_r;
  logic                      out_accepted_r;
  logic [3:0]                out_placed_at_r;
  logic [4:0]                out_entry_count_r;
  logic                      out_entry_valid_r;
  entry_t                    out_entry_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  entry_t            new_entry;
  logic              table_full;
  logic              take;
  logic              shift;
  logic              rd_in_range;

  assign new_entry   = '{score: score_r, name: name_r};
  assign table_full  = (count_r == CNT_W'(TABLE_ENTRIES));
  // On a full table the new score must beat the bottom entry outright.
  assign take        = (score_r > rd_q.score);
  // The stored entry sinks one place when the new score is strictly above it,
  // which keeps equal scores in arrival order.
  assign shift       = (rd_q.score < score_r);
  assign rd_in_range = (CMP_W'(idx_r) < CMP_W'(count_r));

  // Memory port control. Reads are issued in the cycle before their use, and the
  // walk never reads the row that it writes in the same cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = new_entry;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rd_en = 1'b1;
          if (in_operation == OP_READ) begin
            rd_addr = ADDR_W'(in_entry_index);
          end else if (table_full) begin
            rd_addr = LAST_SLOT;
          end else begin
            rd_addr = ADDR_W'(count_r - 1'b1);
          end
        end
      end
      S_CHECK: begin
        rd_en   = take;
        rd_addr = ADDR_W'(LAST_SLOT - 1'b1);
      end
      S_WALK: begin
        wr_en = 1'b1;
        if (shift) begin
          wr_data = rd_q;
          if (slot_r != ADDR_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(slot_r - 2'd2);
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  tkst_store #(
    .DEPTH(TABLE_ENTRIES)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_q),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Sequencer with its registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            idx_r   <= in_entry_index;
            score_r <= in_score;
            name_r  <= clean_name({in_name_word3, in_name_word2,
                                   in_name_word1, in_name_word0});
            if (in_operation == OP_READ) begin
              state_r <= S_RDOUT;
            end else if (table_full) begin
              state_r <= S_CHECK;
            end else begin
              count_r <= count_r + 1'b1;
              slot_r  <= ADDR_W'(count_r);
              state_r <= (count_r == '0) ? S_PLACE : S_WALK;
            end
          end
        end
        S_CHECK: begin
          if (take) begin
            slot_r  <= LAST_SLOT;
            state_r <= S_WALK;
          end else begin
            out_valid_r       <= 1'b1;
            out_accepted_r    <= 1'b0;
            out_placed_at_r   <= '0;
            out_entry_count_r <= 5'(count_r);
            out_entry_valid_r <= 1'b0;
            out_entry_r       <= '0;
            state_r           <= S_IDLE;
          end
        end
        S_WALK: begin
          if (shift) begin
            slot_r  <= ADDR_W'(slot_r - 1'b1);
            state_r <= (slot_r == ADDR_W'(1)) ? S_PLACE : S_WALK;
          end else begin
            out_valid_r       <= 1'b1;
            out_accepted_r    <= 1'b1;
            out_placed_at_r   <= 4'(slot_r);
            out_entry_count_r <= 5'(count_r);
            out_entry_valid_r <= 1'b0;
            out_entry_r       <= '0;
            state_r           <= S_IDLE;
          end
        end
        S_PLACE: begin
          out_valid_r       <= 1'b1;
          out_accepted_r    <= 1'b1;
          out_placed_at_r   <= 4'(slot_r);
          out_entry_count_r <= 5'(count_r);
          out_entry_valid_r <= 1'b0;
          out_entry_r       <= '0;
          state_r           <= S_IDLE;
        end
        S_RDOUT: begin
          out_valid_r       <= 1'b1;
          out_accepted_r    <= 1'b0;
          out_placed_at_r   <= '0;
          out_entry_count_r <= 5'(count_r);
          out_entry_valid_r <= rd_in_range;
          out_entry_r       <= rd_in_range ? rd_q : '0;
          state_r           <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_placed_at   = out_placed_at_r;
  assign out_entry_count = out_entry_count_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_entry_score = out_entry_r.score;
  assign out_entry_name0 = out_entry_r.name[63:0];
  assign out_entry_name1 = out_entry_r.name[127:64];
  assign out_entry_name2 = out_entry_r.name[191:128];
  assign out_entry_name3 = out_entry_r.name[255:192];

  `TKST_ASSERT(a_strobe_when_idle, out_valid_r |-> state_r == S_IDLE, "result shown while busy")
  `TKST_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
  `TKST_ASSERT(a_read_not_accepted, out_valid_r && out_entry_valid_r |-> !out_accepted_r, "read result marked accepted")
  `TKST_ASSERT_NEXT(a_start_busy, start && state_r == S_IDLE, state_r != S_IDLE, "accepted transaction left block idle")
  `TKST_ASSERT_NEXT(a_count_step, start && state_r == S_IDLE && in_operation == OP_INSERT && !table_full, count_r == $past(count_r) + 1'b1, "entry count not advanced on insert")

endmodule
`default_nettype wire
